// ----- design/grm_pkg.sv -----
// Shared constants, types and codes of the grid ray march column block.
package grm_pkg;

    localparam int GRID_COLS    = 32;
    localparam int GRID_ROWS    = 32;
    localparam int FRAC_BITS    = 10;
    localparam int SINE_ENTRIES = 1024;

    localparam int TRIG_BITS   = 14;
    localparam int POS_SHIFT   = FRAC_BITS + TRIG_BITS;
    localparam int POS_W       = POS_SHIFT + 8;
    localparam int STEP_Q      = ((1 << FRAC_BITS) + 5) / 10;
    localparam int SINE_SHIFT  = 16 - $clog2(SINE_ENTRIES);
    localparam int MAG_SHIFT   = TRIG_BITS + 4;
    localparam int GRID_DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int GRID_ADDR_W = $clog2(GRID_DEPTH);
    localparam int COL_W       = $clog2(GRID_COLS);
    localparam int ROW_W       = $clog2(GRID_ROWS);

    localparam int NUM_W   = 48;
    localparam int DEN_W   = 33;
    localparam int V_W     = 31;
    localparam int DIFF_W  = POS_W - TRIG_BITS;
    localparam int SQ_W    = 2 * DIFF_W + 2;
    localparam int SQ_CNT_W = $clog2(SQ_W / 2 + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] REG_FOV    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ANG_GO,
        S_ANG_WAIT,
        S_SIN_PREP,
        S_SIN_GO,
        S_SIN_WAIT,
        S_COS_PREP,
        S_COS_GO,
        S_COS_WAIT,
        S_MARCH_INIT,
        S_MARCH_ADDR,
        S_MARCH_CHECK,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_HT_GO,
        S_HT_WAIT,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DIV_ANG,
        DIV_TRIG,
        DIV_HT
    } div_sel_t;

    typedef struct packed {
        logic     clear_step;
        logic     cell_wr;
        logic     load_item;
        logic     div_start;
        div_sel_t div_sel;
        logic     ang_cap;
        logic     trig_prep;
        logic     trig_cos;
        logic     sin_cap;
        logic     cos_cap;
        logic     march_init;
        logic     march_step;
        logic     hit_set;
        logic     sqrt_start;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_busy;
        logic sqrt_busy;
        logic in_map;
        logic wall;
        logic out_full;
    } status_t;

endpackage

// ----- design/grm_if.sv -----
// Valid/ready channel interfaces for cast items and results.
interface grm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [4:0]  cell_col;
    logic [4:0]  cell_row;
    logic        cell_is_wall;
    logic [14:0] eye_x;
    logic [14:0] eye_y;
    logic [15:0] view_angle;
    logic [9:0]  column;

    modport source (
        output valid, operation, cell_col, cell_row, cell_is_wall,
               eye_x, eye_y, view_angle, column,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_col, cell_row, cell_is_wall,
               eye_x, eye_y, view_angle, column,
        output ready
    );
endinterface

interface grm_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         column_out;
    logic signed [13:0] slice_top;
    logic [12:0]        slice_bottom;
    logic               wall_side;
    logic               hit_wall;
    logic [15:0]        ray_length;

    modport source (
        output valid, column_out, slice_top, slice_bottom, wall_side, hit_wall, ray_length,
        input  ready
    );
    modport sink (
        input  valid, column_out, slice_top, slice_bottom, wall_side, hit_wall, ray_length,
        output ready
    );
endinterface

// ----- design/grm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module grm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/grm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module grm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [grm_pkg::NUM_W-1:0] num,
    input  logic [grm_pkg::DEN_W-1:0] den,
    output logic                      busy,
    output logic [grm_pkg::NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(grm_pkg::NUM_W);

    logic                      busy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [grm_pkg::DEN_W-1:0] rem_reg;
    logic [grm_pkg::DEN_W-1:0] den_reg;
    logic [grm_pkg::NUM_W-1:0] qn_reg;
    logic [grm_pkg::DEN_W:0]   rem_sh;
    logic [grm_pkg::DEN_W:0]   diff;
    logic                      ge;

    assign rem_sh = {rem_reg, qn_reg[grm_pkg::NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign busy   = busy_reg;
    assign quo    = qn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(grm_pkg::NUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            qn_reg  <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[grm_pkg::DEN_W-1:0] : rem_sh[grm_pkg::DEN_W-1:0];
            qn_reg  <= {qn_reg[grm_pkg::NUM_W-2:0], ge};
        end
    end

endmodule

// ----- design/grm_datapath.sv -----
// Datapath: wall grid, trig, ray march, root, height and result register.
module grm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  grm_pkg::cmd_t       cmd,
    output grm_pkg::status_t    status,
    input  logic [14:0]         fov,
    input  logic [10:0]         scr_width,
    input  logic [10:0]         scr_height,
    input  logic [4:0]          cell_col,
    input  logic [4:0]          cell_row,
    input  logic                cell_is_wall,
    input  logic [14:0]         eye_x,
    input  logic [14:0]         eye_y,
    input  logic [15:0]         view_angle,
    input  logic [9:0]          column,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [9:0]          column_out,
    output logic signed [13:0]  slice_top,
    output logic [12:0]         slice_bottom,
    output logic                wall_side,
    output logic                hit_wall,
    output logic [15:0]         ray_length
);

    localparam int PW = grm_pkg::POS_W;
    localparam int AW = grm_pkg::GRID_ADDR_W;

    // control
    logic [AW:0] clr_cnt_reg;
    logic        sq_busy_reg;
    logic [grm_pkg::SQ_CNT_W-1:0] sq_cnt_reg;
    logic        out_valid_reg;

    // payload
    logic [14:0] eye_x_reg, eye_y_reg;
    logic [15:0] view_reg;
    logic [9:0]  col_reg;
    logic [15:0] angle_reg;
    logic [grm_pkg::V_W-1:0] trig_v_reg;
    logic        trig_neg_reg;
    logic [14:0] sin_mag_reg, cos_mag_reg;
    logic        sin_neg_reg, cos_neg_reg;
    logic signed [PW-1:0] step_x_reg, step_y_reg, pos_x_reg, pos_y_reg;
    logic        hit_reg, side_reg;
    logic [grm_pkg::SQ_W-1:0] sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [9:0]  col_out_reg;
    logic [13:0] top_reg;
    logic [12:0] bottom_reg;
    logic        side_out_reg, hit_out_reg;
    logic [15:0] len_out_reg;

    // grid
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic          ram_wdata, ram_rdata;
    logic          cell_in_range;

    // divider
    logic [grm_pkg::NUM_W-1:0] div_num, div_quo;
    logic [grm_pkg::DEN_W-1:0] div_den, trig_den;
    logic                      div_busy;

    // march
    logic          x_ok, y_ok;
    logic [grm_pkg::COL_W-1:0] cx;
    logic [grm_pkg::ROW_W-1:0] cy;

    // trig prep
    logic [15:0] trig_ang, trig_a;
    logic [14:0] trig_u;
    logic signed [15:0] sin_val, cos_val;

    // root
    logic signed [PW-1:0] dpx, dpy;
    logic [PW-1:0] mx, my;
    logic [grm_pkg::DIFF_W-1:0] dx, dy;
    logic [2*grm_pkg::DIFF_W-1:0] sq_x, sq_y;
    logic [grm_pkg::SQ_W-1:0] sq_sum, sq_trial;
    logic sq_ge;

    // height
    logic [20:0] half_full;
    logic [9:0]  mid;
    logic [12:0] half_lim, half;
    logic [grm_pkg::SQ_W-1:0] len_den;

    function automatic logic pos_ok(input logic signed [PW-1:0] p, input int lim);
        logic [PW-grm_pkg::POS_SHIFT-1:0] m;
        m = p[PW-1:grm_pkg::POS_SHIFT];
        if (p < 0)
        begin
            return (&m) && (p[grm_pkg::POS_SHIFT-1:0] != '0);
        end
        return int'(m) < lim;
    endfunction

    // grid memory and its clearing pass
    assign cell_in_range = (int'(cell_col) < grm_pkg::GRID_COLS)
                        && (int'(cell_row) < grm_pkg::GRID_ROWS);
    assign ram_we    = cmd.clear_step || (cmd.cell_wr && cell_in_range);
    assign ram_wdata = cmd.clear_step ? 1'b0 : cell_is_wall;
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg[AW-1:0]
                     : AW'(int'(cell_row) * grm_pkg::GRID_COLS + int'(cell_col));

    assign x_ok = pos_ok(pos_x_reg, grm_pkg::GRID_COLS);
    assign y_ok = pos_ok(pos_y_reg, grm_pkg::GRID_ROWS);
    assign cx = pos_x_reg[PW-1] ? '0
              : pos_x_reg[grm_pkg::POS_SHIFT +: grm_pkg::COL_W];
    assign cy = pos_y_reg[PW-1] ? '0
              : pos_y_reg[grm_pkg::POS_SHIFT +: grm_pkg::ROW_W];
    assign ram_raddr = AW'(int'(cy) * grm_pkg::GRID_COLS + int'(cx));

    grm_ram #(
        .WIDTH(1),
        .DEPTH(grm_pkg::GRID_DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // divider operands
    assign trig_den = grm_pkg::DEN_W'(64'd5 << 30) - {trig_v_reg, 2'b00};
    assign len_den  = (sq_r_reg == '0) ? grm_pkg::SQ_W'(1) : sq_r_reg;

    always_comb
    begin
        case (cmd.div_sel)
            grm_pkg::DIV_ANG:
            begin
                div_num = grm_pkg::NUM_W'({15'd0, col_reg} * {10'd0, fov});
                div_den = (scr_width == '0) ? grm_pkg::DEN_W'(1)
                                            : grm_pkg::DEN_W'(scr_width);
            end
            grm_pkg::DIV_TRIG:
            begin
                div_num = grm_pkg::NUM_W'({trig_v_reg, grm_pkg::MAG_SHIFT'(0)})
                        + grm_pkg::NUM_W'(trig_den >> 1);
                div_den = trig_den;
            end
            grm_pkg::DIV_HT:
            begin
                div_num = grm_pkg::NUM_W'({scr_height, grm_pkg::FRAC_BITS'(0)});
                div_den = grm_pkg::DEN_W'(len_den);
            end
            default:
            begin
                div_num = '0;
                div_den = grm_pkg::DEN_W'(1);
            end
        endcase
    end

    grm_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (div_num),
        .den  (div_den),
        .busy (div_busy),
        .quo  (div_quo)
    );

    // trig entry: angle snapped to the table grid, Bhaskara numerator term
    assign trig_ang = cmd.trig_cos ? angle_reg + 16'd16384 : angle_reg;
    assign trig_a   = {trig_ang[15:grm_pkg::SINE_SHIFT], grm_pkg::SINE_SHIFT'(0)};
    assign trig_u   = trig_a[14:0];
    assign sin_val  = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
    assign cos_val  = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});

    // root operands
    assign dpx = pos_x_reg - $signed(PW'({eye_x_reg, grm_pkg::TRIG_BITS'(0)}));
    assign dpy = pos_y_reg - $signed(PW'({eye_y_reg, grm_pkg::TRIG_BITS'(0)}));
    assign mx  = dpx[PW-1] ? PW'(-dpx) : PW'(dpx);
    assign my  = dpy[PW-1] ? PW'(-dpy) : PW'(dpy);
    assign dx  = mx[PW-1:grm_pkg::TRIG_BITS];
    assign dy  = my[PW-1:grm_pkg::TRIG_BITS];
    assign sq_x = {{grm_pkg::DIFF_W{1'b0}}, dx} * {{grm_pkg::DIFF_W{1'b0}}, dx};
    assign sq_y = {{grm_pkg::DIFF_W{1'b0}}, dy} * {{grm_pkg::DIFF_W{1'b0}}, dy};
    assign sq_sum   = grm_pkg::SQ_W'(sq_x) + grm_pkg::SQ_W'(sq_y);
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign sq_ge    = sq_n_reg >= sq_trial;

    // slice height
    assign mid       = scr_height[10:1];
    assign half_full = div_quo[21:1];
    assign half_lim  = 13'd8191 - {3'b000, mid};
    assign half      = (half_full > {8'd0, half_lim}) ? half_lim : half_full[12:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            sq_busy_reg   <= 1'b0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == grm_pkg::SQ_CNT_W'(grm_pkg::SQ_W / 2 - 1))
                begin
                    sq_busy_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            eye_x_reg <= eye_x;
            eye_y_reg <= eye_y;
            view_reg  <= view_angle;
            col_reg   <= column;
            hit_reg   <= 1'b0;
            side_reg  <= 1'b0;
        end
        if (cmd.ang_cap)
        begin
            angle_reg <= view_reg - {2'b00, fov[14:1]} + div_quo[15:0];
        end
        if (cmd.trig_prep)
        begin
            trig_v_reg   <= {16'd0, trig_u} * (grm_pkg::V_W'(32768) - {16'd0, trig_u});
            trig_neg_reg <= trig_a[15];
        end
        if (cmd.sin_cap)
        begin
            sin_mag_reg <= div_quo[14:0];
            sin_neg_reg <= trig_neg_reg;
        end
        if (cmd.cos_cap)
        begin
            cos_mag_reg <= div_quo[14:0];
            cos_neg_reg <= trig_neg_reg;
        end
        if (cmd.march_init)
        begin
            step_x_reg <= PW'(int'(cos_val) * grm_pkg::STEP_Q);
            step_y_reg <= PW'(int'(sin_val) * grm_pkg::STEP_Q);
            pos_x_reg  <= $signed(PW'({eye_x_reg, grm_pkg::TRIG_BITS'(0)}));
            pos_y_reg  <= $signed(PW'({eye_y_reg, grm_pkg::TRIG_BITS'(0)}));
        end
        else if (cmd.march_step)
        begin
            pos_x_reg <= pos_x_reg + step_x_reg;
            pos_y_reg <= pos_y_reg + step_y_reg;
        end
        if (cmd.hit_set)
        begin
            hit_reg  <= 1'b1;
            side_reg <= (cos_mag_reg > sin_mag_reg) ? 1'b0 : 1'b1;
        end
        if (cmd.sqrt_start)
        begin
            sq_n_reg   <= sq_sum;
            sq_r_reg   <= '0;
            sq_bit_reg <= grm_pkg::SQ_W'(1) << (grm_pkg::SQ_W - 2);
        end
        else if (sq_busy_reg)
        begin
            if (sq_ge)
            begin
                sq_n_reg <= sq_n_reg - sq_trial;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            col_out_reg  <= col_reg;
            top_reg      <= 14'({4'b0000, mid}) - 14'({1'b0, half});
            bottom_reg   <= 13'({3'b000, mid}) + half;
            side_out_reg <= hit_reg & side_reg;
            hit_out_reg  <= hit_reg;
            len_out_reg  <= (sq_r_reg > grm_pkg::SQ_W'(16'hFFFF)) ? 16'hFFFF : sq_r_reg[15:0];
        end
    end

    assign status.clear_done = clr_cnt_reg[AW];
    assign status.div_busy   = div_busy;
    assign status.sqrt_busy  = sq_busy_reg;
    assign status.in_map     = x_ok && y_ok;
    assign status.wall       = ram_rdata;
    assign status.out_full   = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign column_out   = col_out_reg;
    assign slice_top    = $signed(top_reg);
    assign slice_bottom = bottom_reg;
    assign wall_side    = side_out_reg;
    assign hit_wall     = hit_out_reg;
    assign ray_length   = len_out_reg;

endmodule

// ----- design/grm_ctrl.sv -----
// Controller: sequences grid clear, cell writes and the cast of one ray.
module grm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_operation,
    output logic             in_ready,
    input  grm_pkg::status_t status,
    output grm_pkg::cmd_t    cmd
);

    grm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grm_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            grm_pkg::S_CLEAR:
                if (status.clear_done) state_next = grm_pkg::S_IDLE;
            grm_pkg::S_IDLE:
                if (in_valid && in_operation == grm_pkg::OP_CAST) state_next = grm_pkg::S_ANG_GO;
            grm_pkg::S_ANG_GO:    state_next = grm_pkg::S_ANG_WAIT;
            grm_pkg::S_ANG_WAIT:
                if (!status.div_busy) state_next = grm_pkg::S_SIN_PREP;
            grm_pkg::S_SIN_PREP:  state_next = grm_pkg::S_SIN_GO;
            grm_pkg::S_SIN_GO:    state_next = grm_pkg::S_SIN_WAIT;
            grm_pkg::S_SIN_WAIT:
                if (!status.div_busy) state_next = grm_pkg::S_COS_PREP;
            grm_pkg::S_COS_PREP:  state_next = grm_pkg::S_COS_GO;
            grm_pkg::S_COS_GO:    state_next = grm_pkg::S_COS_WAIT;
            grm_pkg::S_COS_WAIT:
                if (!status.div_busy) state_next = grm_pkg::S_MARCH_INIT;
            grm_pkg::S_MARCH_INIT: state_next = grm_pkg::S_MARCH_ADDR;
            grm_pkg::S_MARCH_ADDR:
                state_next = status.in_map ? grm_pkg::S_MARCH_CHECK : grm_pkg::S_SQRT_GO;
            grm_pkg::S_MARCH_CHECK:
                state_next = status.wall ? grm_pkg::S_SQRT_GO : grm_pkg::S_MARCH_ADDR;
            grm_pkg::S_SQRT_GO:   state_next = grm_pkg::S_SQRT_WAIT;
            grm_pkg::S_SQRT_WAIT:
                if (!status.sqrt_busy) state_next = grm_pkg::S_HT_GO;
            grm_pkg::S_HT_GO:     state_next = grm_pkg::S_HT_WAIT;
            grm_pkg::S_HT_WAIT:
                if (!status.div_busy) state_next = grm_pkg::S_FINISH;
            grm_pkg::S_FINISH:
                if (!status.out_full) state_next = grm_pkg::S_IDLE;
            default:              state_next = grm_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            grm_pkg::S_CLEAR:
                cmd.clear_step = !status.clear_done;
            grm_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid && in_operation == grm_pkg::OP_CAST;
                cmd.cell_wr   = in_valid && in_operation == grm_pkg::OP_WRITE;
            end
            grm_pkg::S_ANG_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grm_pkg::DIV_ANG;
            end
            grm_pkg::S_ANG_WAIT:
                cmd.ang_cap = !status.div_busy;
            grm_pkg::S_SIN_PREP:
                cmd.trig_prep = 1'b1;
            grm_pkg::S_SIN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grm_pkg::DIV_TRIG;
            end
            grm_pkg::S_SIN_WAIT:
                cmd.sin_cap = !status.div_busy;
            grm_pkg::S_COS_PREP:
            begin
                cmd.trig_prep = 1'b1;
                cmd.trig_cos  = 1'b1;
            end
            grm_pkg::S_COS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grm_pkg::DIV_TRIG;
            end
            grm_pkg::S_COS_WAIT:
                cmd.cos_cap = !status.div_busy;
            grm_pkg::S_MARCH_INIT:
                cmd.march_init = 1'b1;
            grm_pkg::S_MARCH_ADDR:
                cmd.march_step = !status.in_map;
            grm_pkg::S_MARCH_CHECK:
            begin
                cmd.march_step = 1'b1;
                cmd.hit_set    = status.wall;
            end
            grm_pkg::S_SQRT_GO:
                cmd.sqrt_start = 1'b1;
            grm_pkg::S_HT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grm_pkg::DIV_HT;
            end
            grm_pkg::S_FINISH:
                cmd.out_load = !status.out_full;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ----- design/grid_ray_march_column.sv -----
// Top level of the grid ray march column block: register port and wiring.
//
// Usage: items arrive on in_ch. operation 0 writes one wall bit of the 32x32
// grid and produces no result; operation 1 casts the ray of one screen column
// and produces one result on out_ch. A transfer happens at a rising edge with
// valid and ready both high. Field of view, screen width and screen height
// are to be written by the user through the APB port only while the block
// is idle; the block itself does not enforce this. A cast marches the ray
// at 0.1-cell steps until it hits a wall or leaves the map; each check of a
// cell has one state for the cell address and one for the registered grid
// read. It runs the shared one-bit-per-cycle divider four times (angle,
// sine, cosine, height) and a 19-step root. One cast is in flight at a time;
// the next item is taken the cycle after the result is loaded.
// After reset the grid is cleared one cell a cycle: in_ch.ready stays low
// until every cell is cleared, then items are taken. A finished result waits
// in the output register while out_ch.ready is low; cell writes and a new
// cast are still taken meanwhile, and a later cast holds before its result
// slot until the waiting result is transferred.
module grid_ray_march_column (
    input  logic        clk,
    input  logic        rst_n,
    grm_in_if.sink      in_ch,
    grm_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [14:0] fov_reg, fov_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic        cfg_wr;

    grm_pkg::cmd_t    cmd;
    grm_pkg::status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        fov_next    = fov_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                grm_pkg::REG_FOV:    fov_next    = pwdata[14:0];
                grm_pkg::REG_WIDTH:  width_next  = pwdata[10:0];
                grm_pkg::REG_HEIGHT: height_next = pwdata[10:0];
                default:             fov_next    = fov_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_reg    <= 15'd10923;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else
        begin
            fov_reg    <= fov_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            grm_pkg::REG_FOV:    prdata = {17'd0, fov_reg};
            grm_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            grm_pkg::REG_HEIGHT: prdata = {21'd0, height_reg};
            default:             prdata = '0;
        endcase
    end

    grm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_operation(in_ch.operation),
        .in_ready    (in_ch.ready),
        .status      (status),
        .cmd         (cmd)
    );

    grm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .fov         (fov_reg),
        .scr_width   (width_reg),
        .scr_height  (height_reg),
        .cell_col    (in_ch.cell_col),
        .cell_row    (in_ch.cell_row),
        .cell_is_wall(in_ch.cell_is_wall),
        .eye_x       (in_ch.eye_x),
        .eye_y       (in_ch.eye_y),
        .view_angle  (in_ch.view_angle),
        .column      (in_ch.column),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .column_out  (out_ch.column_out),
        .slice_top   (out_ch.slice_top),
        .slice_bottom(out_ch.slice_bottom),
        .wall_side   (out_ch.wall_side),
        .hit_wall    (out_ch.hit_wall),
        .ray_length  (out_ch.ray_length)
    );

endmodule
